FILE: rtl/itra_pkg.sv
// Package for integer_to_radix_ascii: word types, controller/datapath link types,
// digit-to-ASCII helper. No dependencies.
package itra_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int STEP_BITS       = 8;

    localparam logic [4:0] RADIX_MIN = 5'd2;
    localparam logic [4:0] RADIX_DEC = 5'd10;
    localparam logic [4:0] RADIX_HEX = 5'd16;

    localparam logic [6:0] ASCII_ZERO = 7'h30;
    localparam logic [6:0] ASCII_A    = 7'h41;

    typedef struct packed {
        logic [63:0] value;
        logic [4:0]  radix;
    } t_in_word;

    typedef struct packed {
        logic [6:0] digit_char;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic step;
        logic store;
        logic rd_en;
    } t_dp_cmd;

    typedef struct packed {
        logic pass_last;
        logic quot_nz;
        logic rd_last;
    } t_dp_stat;

    function automatic logic [6:0] digit_ascii(input logic [3:0] d);
        if (d < 4'd10) begin
            return ASCII_ZERO + {3'b000, d};
        end
        return ASCII_A + {3'b000, d} - 7'd10;
    endfunction

endpackage

FILE: rtl/itra_dp.sv
// Datapath for integer_to_radix_ascii: long division by the radix, STEP_BITS
// bits a cycle, digit store and character read-out. Depends on itra_pkg.
module itra_dp
    import itra_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_word o_data
);

    localparam int PASSES = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int QW     = PASSES * STEP_BITS;
    localparam int PW     = (PASSES > 1) ? $clog2(PASSES) : 1;
    localparam int AW     = $clog2(VALUE_WIDTH);

    logic [QW-1:0]        r_num;
    logic [3:0]           r_rem;
    logic [4:0]           r_radix;
    logic [PW-1:0]        r_pass;
    logic                 r_qnz;
    logic [AW-1:0]        r_wr;
    logic [AW-1:0]        r_rd;
    logic [3:0]           r_rdata;
    logic                 r_last;
    logic [3:0]           r_mem [VALUE_WIDTH];

    logic [STEP_BITS-1:0]    n_qbits;
    logic [3:0]              n_rem;
    logic [QW+STEP_BITS-1:0] n_shift;
    logic [4:0]              n_radix;
    logic [STEP_BITS-1:0]    top_bits;
    logic [4:0]              part;

    assign top_bits = r_num[QW-1 -: STEP_BITS];

    always_comb begin
        n_rem = r_rem;
        part  = 5'd0;
        for (int k = STEP_BITS - 1; k >= 0; k--) begin
            part = {n_rem, top_bits[k]};
            if (part >= r_radix) begin
                n_qbits[k] = 1'b1;
                part       = part - r_radix;
            end else begin
                n_qbits[k] = 1'b0;
            end
            n_rem = part[3:0];
        end
        n_shift = {r_num, n_qbits};
    end

    always_comb begin
        if (i_data.radix < RADIX_MIN) begin
            n_radix = RADIX_DEC;
        end else if (i_data.radix > RADIX_HEX) begin
            n_radix = RADIX_HEX;
        end else begin
            n_radix = i_data.radix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= '0;
        end else if (i_cmd.load || i_cmd.store) begin
            r_pass <= '0;
        end else if (i_cmd.step) begin
            r_pass <= r_pass + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num   <= QW'(i_data.value[VALUE_WIDTH-1:0]);
            r_rem   <= '0;
            r_radix <= n_radix;
            r_wr    <= '0;
        end else if (i_cmd.step) begin
            r_num <= n_shift[QW-1:0];
            r_rem <= n_rem;
            r_qnz <= ((r_pass == '0) ? 1'b0 : r_qnz) | (|n_qbits);
        end else if (i_cmd.store) begin
            r_mem[r_wr] <= r_rem;
            r_rd        <= r_wr;
            r_wr        <= r_wr + AW'(1);
            r_rem       <= '0;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[r_rd];
            r_last  <= (r_rd == '0);
            r_rd    <= r_rd - AW'(1);
        end
    end

    assign o_stat.pass_last = (r_pass == PW'(PASSES - 1));
    assign o_stat.quot_nz   = r_qnz;
    assign o_stat.rd_last   = r_last;

    assign o_data.digit_char = digit_ascii(r_rdata);
    assign o_data.last       = r_last;

endmodule

FILE: rtl/itra_ctrl.sv
// Controller for integer_to_radix_ascii: sequences load, division passes,
// digit stores and character read-out. Depends on itra_pkg.
module itra_ctrl
    import itra_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    output logic     o_valid,
    input  logic     i_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_STORE = 5'b00100,
        S_FETCH = 5'b01000,
        S_SHOW  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_stat.pass_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = i_stat.quot_nz ? S_DIV : S_FETCH;
            end
            S_FETCH: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_SHOW;
            end
            S_SHOW: begin
                if (i_ready) begin
                    if (i_stat.rd_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rd_en = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_SHOW);

endmodule

FILE: rtl/integer_to_radix_ascii.sv
// Top level of integer_to_radix_ascii: controller plus division datapath.
// Depends on itra_pkg, itra_ctrl, itra_dp.
//
//   channel | handshake          | word
//   --------+--------------------+---------------------------------
//   input   | i_valid / o_ready  | i_data  (value, radix)
//   output  | o_valid / i_ready  | o_data  (digit_char, last)
//
// Each digit takes ceil(VALUE_WIDTH/8) division passes plus one store, set by the
// 8-bit-a-cycle long division unit.
// After the last digit a fetch state, then one character per cycle while the output
// is ready, from the registered digit memory.
// Output stalls hold the current character; a new word is taken only when idle.
// Synchronous active-low reset returns the controller to idle.
module integer_to_radix_ascii
    import itra_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    itra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    itra_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_data  (o_data)
    );

endmodule
